### src/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

	// Ring size and derived widths
	localparam int unsigned DEPTH  = 32;
	localparam int unsigned AW     = $clog2(DEPTH);
	localparam int unsigned CW     = $clog2(DEPTH + 1);
	localparam int unsigned DW     = 32;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned STAT_W = 2;

	typedef logic [AW-1:0]     slot_t;
	typedef logic [CW-1:0]     count_t;
	typedef logic [DW-1:0]     word_t;
	typedef logic [POS_W-1:0]  pos_t;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP_FWD   = 3'd4,
		CMD_DUMP_REV   = 3'd5
	} cmd_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Write port of the entry store
	typedef struct packed {
		logic  en;
		slot_t addr;
		word_t data;
	} wr_req_t;

	// Read port of the entry store
	typedef struct packed {
		logic  en;
		slot_t addr;
	} rd_req_t;

	// (slot + offset) mod DEPTH, offset at most DEPTH
	function automatic slot_t slot_add(slot_t slot, count_t offset);
		logic [CW:0] sum;
		begin
			sum = {{(CW + 1 - AW){1'b0}}, slot} + {1'b0, offset};
			if (sum >= (CW + 1)'(DEPTH)) begin
				sum = sum - (CW + 1)'(DEPTH);
			end
			return sum[AW-1:0];
		end
	endfunction

	// One slot toward the back (fwd) or toward the front (rev), wrapping
	function automatic slot_t slot_step(slot_t slot, logic rev);
		begin
			if (rev) begin
				return (slot == '0) ? slot_t'(DEPTH - 1) : slot - slot_t'(1);
			end
			return (slot == slot_t'(DEPTH - 1)) ? '0 : slot + slot_t'(1);
		end
	endfunction

endpackage

### src/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram (
	input  logic            clk,
	input  dq_pkg::wr_req_t wr,
	input  dq_pkg::rd_req_t rd,
	output dq_pkg::word_t   rdata
);

	dq_pkg::word_t mem_q [dq_pkg::DEPTH];
	dq_pkg::word_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read port; output holds until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words kept in a ring buffer.
// Input channel (in_valid/in_ready): cmd and value. Commands push at the
// front or back, pop from the front or back, or dump every entry front to
// back or back to front. Output channel (out_valid/out_ready): data,
// position, status and last; last marks the final word of each command.
// A push, or any command that hits a full or empty queue, gives one word
// in the cycle after acceptance. A pop reads the entry RAM (registered
// read) at acceptance; its word passes through the read-in-flight
// register to the output register. A dump of N entries streams one word
// per cycle from the RAM read port while the receiver does not stall,
// by the same path. Codes 6 and 7 are taken and dropped.
// A new command is taken only once the previous one has issued all its
// reads and its read data has moved to the output register.
// When the receiver stalls, the output register holds its word and the
// read stream pauses with the pending RAM data held in place.
// Reset empties the queue and clears the front pointer; the entry RAM is
// not cleared, as only occupied slots are ever read.
module double_ended_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dq_pkg::CMD_W-1:0]      cmd,
	input  logic signed [dq_pkg::DW-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [dq_pkg::DW-1:0]  data,
	output logic [dq_pkg::POS_W-1:0]      position,
	output logic [dq_pkg::STAT_W-1:0]     status,
	output logic                          last
);

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t          state_q;
	dq_pkg::slot_t   front_q;
	dq_pkg::count_t  occ_q;

	// Read stream bookkeeping
	dq_pkg::slot_t   cur_q;
	dq_pkg::count_t  rem_q;
	dq_pkg::pos_t    pos_q;
	logic            rev_q;

	// Read in flight: RAM data valid next cycle
	logic            pend_s1;
	logic            pend_last_s1;
	dq_pkg::pos_t    pend_pos_s1;

	// Output register
	logic            out_valid_q;
	dq_pkg::word_t   data_q;
	dq_pkg::pos_t    position_q;
	dq_pkg::status_t status_q;
	logic            last_q;

	dq_pkg::wr_req_t wr;
	dq_pkg::rd_req_t rd;
	dq_pkg::word_t   rdata;

	logic            out_free;
	logic            in_acc;
	logic            is_full;
	logic            is_empty;
	dq_pkg::slot_t   back_slot;
	dq_pkg::slot_t   tail_slot;
	dq_pkg::slot_t   front_dec;

	logic            start_rd;
	dq_pkg::slot_t   start_slot;
	dq_pkg::count_t  start_cnt;
	logic            start_rev;
	logic            imm_load;
	dq_pkg::status_t imm_status;
	dq_pkg::slot_t   front_d;
	dq_pkg::count_t  occ_d;
	logic            st_rd;
	logic            rd_last;
	dq_pkg::pos_t    rd_pos;

	dq_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	// Handshake
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !pend_s1 && out_free;
	assign in_acc   = in_valid && in_ready;

	// Ring positions
	assign is_full   = (occ_q == dq_pkg::count_t'(dq_pkg::DEPTH));
	assign is_empty  = (occ_q == '0);
	assign back_slot = dq_pkg::slot_add(front_q, occ_q - dq_pkg::count_t'(1));
	assign tail_slot = dq_pkg::slot_add(front_q, occ_q);
	assign front_dec = dq_pkg::slot_step(front_q, 1'b1);

	// Command decode at acceptance
	always_comb begin
		wr         = '{en: 1'b0, addr: tail_slot, data: dq_pkg::word_t'(value)};
		start_rd   = 1'b0;
		start_slot = front_q;
		start_cnt  = dq_pkg::count_t'(1);
		start_rev  = 1'b0;
		imm_load   = 1'b0;
		imm_status = dq_pkg::STAT_OK;
		front_d    = front_q;
		occ_d      = occ_q;
		if (in_acc) begin
			unique case (cmd)
				dq_pkg::CMD_PUSH_FRONT: begin
					imm_load = 1'b1;
					if (is_full) begin
						imm_status = dq_pkg::STAT_FULL;
					end else begin
						wr.en   = 1'b1;
						wr.addr = front_dec;
						front_d = front_dec;
						occ_d   = occ_q + dq_pkg::count_t'(1);
					end
				end
				dq_pkg::CMD_PUSH_BACK: begin
					imm_load = 1'b1;
					if (is_full) begin
						imm_status = dq_pkg::STAT_FULL;
					end else begin
						wr.en = 1'b1;
						occ_d = occ_q + dq_pkg::count_t'(1);
					end
				end
				dq_pkg::CMD_POP_FRONT: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = dq_pkg::STAT_EMPTY;
					end else begin
						start_rd = 1'b1;
						front_d  = dq_pkg::slot_step(front_q, 1'b0);
						occ_d    = occ_q - dq_pkg::count_t'(1);
					end
				end
				dq_pkg::CMD_POP_BACK: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = dq_pkg::STAT_EMPTY;
					end else begin
						start_rd   = 1'b1;
						start_slot = back_slot;
						occ_d      = occ_q - dq_pkg::count_t'(1);
					end
				end
				dq_pkg::CMD_DUMP_FWD: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = dq_pkg::STAT_EMPTY;
					end else begin
						start_rd  = 1'b1;
						start_cnt = occ_q;
					end
				end
				dq_pkg::CMD_DUMP_REV: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = dq_pkg::STAT_EMPTY;
					end else begin
						start_rd   = 1'b1;
						start_slot = back_slot;
						start_cnt  = occ_q;
						start_rev  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// RAM read issue: first read at acceptance, the rest from the stream state
	assign st_rd   = (state_q == ST_STREAM) && (!pend_s1 || out_free);
	assign rd.en   = start_rd || st_rd;
	assign rd.addr = st_rd ? cur_q : start_slot;
	assign rd_last = st_rd ? (rem_q == dq_pkg::count_t'(1))
		: (start_cnt == dq_pkg::count_t'(1));
	assign rd_pos  = st_rd ? pos_q : '0;

	// State, stream control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			front_q      <= '0;
			occ_q        <= '0;
			cur_q        <= '0;
			rem_q        <= '0;
			pos_q        <= '0;
			rev_q        <= 1'b0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
			pend_pos_s1  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			front_q <= front_d;
			occ_q   <= occ_d;

			unique case (state_q)
				ST_IDLE: begin
					if (start_rd && (start_cnt != dq_pkg::count_t'(1))) begin
						state_q <= ST_STREAM;
						cur_q   <= dq_pkg::slot_step(start_slot, start_rev);
						rem_q   <= start_cnt - dq_pkg::count_t'(1);
						pos_q   <= dq_pkg::pos_t'(1);
						rev_q   <= start_rev;
					end
				end
				ST_STREAM: begin
					if (st_rd) begin
						cur_q <= dq_pkg::slot_step(cur_q, rev_q);
						rem_q <= rem_q - dq_pkg::count_t'(1);
						pos_q <= pos_q + dq_pkg::pos_t'(1);
						if (rem_q == dq_pkg::count_t'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Read in flight
			if (rd.en) begin
				pend_s1      <= 1'b1;
				pend_last_s1 <= rd_last;
				pend_pos_s1  <= rd_pos;
			end else if (pend_s1 && out_free) begin
				pend_s1 <= 1'b0;
			end

			// Output word
			if (pend_s1 && out_free) begin
				out_valid_q <= 1'b1;
				data_q      <= rdata;
				position_q  <= pend_pos_s1;
				status_q    <= dq_pkg::STAT_OK;
				last_q      <= pend_last_s1;
			end else if (imm_load) begin
				out_valid_q <= 1'b1;
				data_q      <= '0;
				position_q  <= '0;
				status_q    <= imm_status;
				last_q      <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign position  = position_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	// Occupancy never exceeds the ring size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= dq_pkg::count_t'(dq_pkg::DEPTH))
		else $error("occupancy above ring size");

	// Every issued read leaves a word pending in the next cycle
	a_read_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |=> pend_s1)
		else $error("issued read not pending");

	// Stream state always has reads left to issue
	a_stream_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> (rem_q != '0))
		else $error("stream state with no reads left");

	// Pending read data waits while the output register is stalled
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && !out_free) |=> (pend_s1 && $stable(pend_pos_s1)))
		else $error("pending read lost under stall");
`endif

endmodule
